// ----- hdl/adler32_multibyte_core_assert.svh -----
// ----------------------------------------------------------------------------
// Adler-32 multibyte core assertion macros
// Shared property shapes for the checker of the Adler-32 core.
// ----------------------------------------------------------------------------
`ifndef ADLER32_MULTIBYTE_CORE_ASSERT_SVH
`define ADLER32_MULTIBYTE_CORE_ASSERT_SVH

// Antecedent in one cycle implies the consequent in the next, outside reset.
`define ADL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Same shape, but also checked while reset is applied.
`define ADL_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/adler_pkg.sv -----
// ----------------------------------------------------------------------------
// Adler-32 multibyte package
// Widths, the queue entry type and the modulo 65521 reduction helper.
// ----------------------------------------------------------------------------
package adler_pkg;

  localparam int unsigned DATA_W      = 64;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned CHECKSUM_W  = 32;
  localparam int unsigned TDATA_W     = 72;
  localparam int unsigned MAX_LANES   = 8;
  // Count width covers up to 64 bytes per request.
  localparam int unsigned CNT_W       = 7;
  // Plain byte sum of up to eight bytes.
  localparam int unsigned BSUM_W      = 11;
  // Weighted byte sum: weight up to 64, eight lanes of 255.
  localparam int unsigned WSUM_W      = 18;
  localparam int unsigned RED_W       = 24;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SUM_W-1:0]      ADLER_MOD  = 16'hFFF1;
  localparam logic [CHECKSUM_W-1:0] SEED_RESET = 32'h0000_0001;

  // One classified request as it waits between front and back end.
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [BSUM_W-1:0] bsum;
    logic [SUM_W-1:0]  wsum;
    logic              last;
  } adler_entry_t;

  // Reduce a value below 2^24 modulo 65521: fold the upper byte using
  // 2^16 = 15 (mod 65521), then one conditional subtract.
  function automatic logic [SUM_W-1:0] adler_mod(input logic [RED_W-1:0] x);
    logic [SUM_W:0] t;
    t = (SUM_W+1)'(x[SUM_W-1:0]) + (SUM_W+1)'(x[RED_W-1:SUM_W]) * (SUM_W+1)'(15);
    if (t >= (SUM_W+1)'(ADLER_MOD)) begin
      t = t - (SUM_W+1)'(ADLER_MOD);
    end
    return t[SUM_W-1:0];
  endfunction

endpackage

// ----- hdl/adler32_multibyte_core.sv -----
// ----------------------------------------------------------------------------
// Adler-32 multibyte core
// Path: a last request's checksum is valid on m_axis after the queue write
// and then the sum update into the output register.
// Throughput: one request of up to BYTES_PER_ITEM bytes per cycle, unless a
// last request waits for a stalled output. Reset empties the queue and output
// and loads both sums from the seed 0x00000001.
// ----------------------------------------------------------------------------
module adler32_multibyte_core #(
  parameter int unsigned BYTES_PER_ITEM = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Seed register write.
  input  logic                             cfg_we_i,
  input  logic [adler_pkg::CHECKSUM_W-1:0] cfg_wdata_i,
  // Input stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: data_bytes [63:0], byte_count [67:64], zero pad [71:68].
  input  logic [adler_pkg::TDATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tlast,
  // Output stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: checksum [31:0].
  output logic [adler_pkg::CHECKSUM_W-1:0] m_axis_tdata
);
  import adler_pkg::*;

  adler_entry_t front_entry;
  adler_entry_t queue_entry;
  logic         queue_full;
  logic         queue_valid;
  logic         queue_pop;
  logic         push;

  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  // Classify the incoming request.
  adler_front #(
    .BYTES_PER_ITEM(BYTES_PER_ITEM)
  ) u_front (
    .data_i (s_axis_tdata[DATA_W-1:0]),
    .count_i(s_axis_tdata[DATA_W +: COUNT_W]),
    .last_i (s_axis_tlast),
    .entry_o(front_entry)
  );

  // Decoupling queue.
  adler_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(front_entry),
    .full_o (queue_full),
    .pop_i  (queue_pop),
    .valid_o(queue_valid),
    .entry_o(queue_entry)
  );

  // Running sums and checksum output.
  adler_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .entry_valid_i(queue_valid),
    .entry_i      (queue_entry),
    .entry_pop_o  (queue_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .checksum_o   (m_axis_tdata)
  );

endmodule

// ----- hdl/adler_front.sv -----
// ----------------------------------------------------------------------------
// Adler-32 front end
// Decodes the byte count and folds the bytes of one request into a plain
// byte sum and a position-weighted sum, ready for the back end.
// ----------------------------------------------------------------------------
module adler_front #(
  parameter int unsigned BYTES_PER_ITEM = 8
) (
  input  logic [adler_pkg::DATA_W-1:0]  data_i,
  input  logic [adler_pkg::COUNT_W-1:0] count_i,
  input  logic                          last_i,
  output adler_pkg::adler_entry_t       entry_o
);
  import adler_pkg::*;

  localparam int unsigned LANES = (BYTES_PER_ITEM < MAX_LANES) ? BYTES_PER_ITEM : MAX_LANES;
  localparam logic [CNT_W-1:0] NFULL = CNT_W'(BYTES_PER_ITEM);

  logic [CNT_W-1:0]  cnt;
  logic [BSUM_W-1:0] bsum;
  logic [WSUM_W-1:0] wsum;

  // A count of zero or above the request width means a full request.
  always_comb begin
    if (count_i == '0 || CNT_W'(count_i) > NFULL) begin
      cnt = NFULL;
    end else begin
      cnt = CNT_W'(count_i);
    end
  end

  // Byte i is seen by the high sum (cnt - i) times; bytes past the data
  // field are zero and contribute nothing.
  always_comb begin
    bsum = '0;
    wsum = '0;
    for (int i = 0; i < LANES; i++) begin
      if (CNT_W'(i) < cnt) begin
        bsum = bsum + BSUM_W'(data_i[8*i +: 8]);
        wsum = wsum + WSUM_W'(cnt - CNT_W'(i)) * WSUM_W'(data_i[8*i +: 8]);
      end
    end
  end

  assign entry_o.cnt  = cnt;
  assign entry_o.bsum = bsum;
  assign entry_o.wsum = adler_mod(RED_W'(wsum));
  assign entry_o.last = last_i;

endmodule

// ----- hdl/adler_fifo.sv -----
// ----------------------------------------------------------------------------
// Adler-32 request queue
// Short queue of classified requests between the front and back end.
// ----------------------------------------------------------------------------
module adler_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  adler_pkg::adler_entry_t entry_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    valid_o,
  output adler_pkg::adler_entry_t entry_o
);
  import adler_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

  adler_entry_t     mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (level_q == LVL_W'(QUEUE_DEPTH));
  assign valid_o = (level_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer wrap and fill level.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      level_d = level_q + LVL_W'(1);
    end else if (do_pop && !do_push) begin
      level_d = level_q - LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- hdl/adler_back.sv -----
// ----------------------------------------------------------------------------
// Adler-32 back end
// Holds the seed and both sums, applies one queued request per cycle unless a
// last request awaits a free output, and drives the checksum output register.
// ----------------------------------------------------------------------------
module adler_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [adler_pkg::CHECKSUM_W-1:0] cfg_wdata_i,
  input  logic                             entry_valid_i,
  input  adler_pkg::adler_entry_t          entry_i,
  output logic                             entry_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [adler_pkg::CHECKSUM_W-1:0] checksum_o
);
  import adler_pkg::*;

  logic [CHECKSUM_W-1:0] seed_q;
  logic [SUM_W-1:0]      low_q, low_d;
  logic [SUM_W-1:0]      high_q, high_d;
  logic                  out_valid_q;
  logic [CHECKSUM_W-1:0] checksum_q;
  logic                  out_free;

  // A last request may only leave when the output register is free.
  assign out_free    = !out_valid_q || out_ready_i;
  assign entry_pop_o = entry_valid_i && (!entry_i.last || out_free);

  // New low sum adds the byte sum; new high sum adds cnt times the old
  // low sum plus the weighted byte sum.
  always_comb begin
    low_d  = adler_mod(RED_W'(low_q) + RED_W'(entry_i.bsum));
    high_d = adler_mod(RED_W'(high_q) + RED_W'(entry_i.cnt) * RED_W'(low_q)
                       + RED_W'(entry_i.wsum));
  end

  // Seed and running sums; a seed write or a last request reloads the sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
      low_q  <= SEED_RESET[SUM_W-1:0];
      high_q <= SEED_RESET[CHECKSUM_W-1:SUM_W];
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
      low_q  <= cfg_wdata_i[SUM_W-1:0];
      high_q <= cfg_wdata_i[CHECKSUM_W-1:SUM_W];
    end else if (entry_pop_o) begin
      if (entry_i.last) begin
        low_q  <= seed_q[SUM_W-1:0];
        high_q <= seed_q[CHECKSUM_W-1:SUM_W];
      end else begin
        low_q  <= low_d;
        high_q <= high_d;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (entry_pop_o && entry_i.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Checksum payload.
  always_ff @(posedge clk_i) begin
    if (entry_pop_o && entry_i.last) begin
      checksum_q <= {high_d, low_d};
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = checksum_q;

endmodule

// ----- hdl/adler_checker.sv -----
// ----------------------------------------------------------------------------
// Adler-32 port checker
// Checks reset, output stall and input progress behavior at the ports.
// ----------------------------------------------------------------------------
`include "adler32_multibyte_core_assert.svh"

module adler_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_we_i,
  input logic [adler_pkg::CHECKSUM_W-1:0] cfg_wdata_i,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [adler_pkg::TDATA_W-1:0]    s_axis_tdata,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [adler_pkg::CHECKSUM_W-1:0] m_axis_tdata
);

  // A stalled checksum stays valid and unchanged.
  `ADL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "checksum changed while stalled")

  // A full queue drains one request whenever the output side can move.
  `ADL_ASSERT_NEXT(a_in_progress, !s_axis_tready && (!m_axis_tvalid || m_axis_tready), s_axis_tready, "input stalled although output was free")

  // Reset leaves the output empty and the input ready.
  `ADL_ASSERT_NEXT_RST(a_reset_state, !rst_ni, !m_axis_tvalid && s_axis_tready, "bad state after reset")

endmodule

bind adler32_multibyte_core adler_checker u_adler_checker (.*);
